[rtl/assert_macros.svh]
// Assertion helpers included by timer_divider_solver_top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is high.
`define TDS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define TDS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/tds_pkg.sv]
package tds_pkg;

   // Field widths
   localparam int FREQ_W = 16;
   localparam int CLK_W  = 32;
   localparam int PSC_W  = 16;
   localparam int RLD_W  = 16;
   localparam int IDX_W  = 8;

   // Valid target range
   localparam logic [FREQ_W-1:0] FREQ_MIN = 16'd1;
   localparam logic [FREQ_W-1:0] FREQ_MAX = 16'd5000;

   // Sample rate holds FREQ_MAX times the largest samples per cycle (4096)
   localparam int SPC_W  = 13;
   localparam int PROD_W = FREQ_W + SPC_W;
   localparam int RATE_W = 25;

   // Divisor holds 65537 * rate and 65536 * rate
   localparam int DIV_W = RATE_W + 17;

   // Prescaler plus one spans 1..65536
   localparam int MPL_W = PSC_W + 1;
   localparam int QUO_W = PSC_W + 1;

   // Sequencer step counts
   localparam int CNT_W     = 5;
   localparam int DIV_STEPS = CLK_W;
   localparam int MUL_STEPS = MPL_W;

   // Register indexes
   localparam logic [IDX_W-1:0] CSR_BUS_CLOCK   = 8'd0;
   localparam logic [IDX_W-1:0] CSR_BUS_DIVIDED = 8'd1;

   // Register reset values
   localparam logic [CLK_W-1:0] BUS_CLOCK_RESET   = 32'd42000000;
   localparam logic             BUS_DIVIDED_RESET = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCALE,
      S_DIV1,
      S_MUL,
      S_DIV2,
      S_DONE
   } tds_state_type;

endpackage

[rtl/timer_divider_solver_top.sv]
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    req_target_freq_hz
// rsp       out        rsp_valid/rsp_ready    rsp_ok, rsp_prescale, rsp_reload
// csr       in         csr_valid/csr_ready    csr_index, csr_data
//
// One word at a time: an accepted target passes a scale step, a 32-step
// bit-serial restoring division for the prescaler, a 17-step shift-add multiply,
// a second 32-step division for the reload and a done step; a rejected one
// goes straight to done. One shared divider yields one quotient bit per cycle.
// Reset is synchronous, active high; it restores the clock registers and idles.
// A result waits in the rsp register; the next req word is taken meanwhile.
// csr is always ready; write it only while idle.
module timer_divider_solver_top #(
   parameter int SAMPLES_PER_CYCLE = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [tds_pkg::FREQ_W-1:0]  req_target_freq_hz,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_ok,
   output logic [tds_pkg::PSC_W-1:0]   rsp_prescale,
   output logic [tds_pkg::RLD_W-1:0]   rsp_reload,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [tds_pkg::IDX_W-1:0]   csr_index,
   input  logic [tds_pkg::CLK_W-1:0]   csr_data
);
   import tds_pkg::*;
`include "assert_macros.svh"

   localparam logic [SPC_W-1:0] SPC = SPC_W'(SAMPLES_PER_CYCLE);

   tds_state_type state_ff, state_in;

   logic [CLK_W-1:0]  bus_clock_ff;
   logic              bus_divided_ff;
   logic [CLK_W-1:0]  tclk_ff, tclk_in;
   logic [RATE_W-1:0] rate_ff, rate_in;
   logic [DIV_W-1:0]  div_ff, div_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [CLK_W-1:0]  quo_ff, quo_in;
   logic [MPL_W-1:0]  mpl_ff, mpl_in;
   logic [DIV_W-1:0]  mcd_ff, mcd_in;
   logic [PSC_W-1:0]  psc_ff, psc_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              res_ok_ff, res_ok_in;
   logic [PSC_W-1:0]  res_psc_ff, res_psc_in;
   logic [RLD_W-1:0]  res_rld_ff, res_rld_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic [PSC_W-1:0]  rsp_psc_ff, rsp_psc_in;
   logic [RLD_W-1:0]  rsp_rld_ff, rsp_rld_in;

   logic              req_take;
   logic              out_free;
   logic [CLK_W-1:0]  tclk_now;
   logic              reject;
   logic [PROD_W-1:0] rate_prod;
   logic [DIV_W:0]    trial;
   logic [DIV_W:0]    diff;
   logic              ge;
   logic [CLK_W-1:0]  quo_next;
   logic [QUO_W-1:0]  q_val;
   logic              div_last;
   logic              mul_last;

   assign req_ready = (state_ff == S_IDLE);
   assign req_take  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   // Timer clock: zero stays zero, otherwise double with wrap when divided
   always_comb begin
      if (bus_clock_ff == '0) begin
         tclk_now = '0;
      end else if (bus_divided_ff) begin
         tclk_now = {bus_clock_ff[CLK_W-2:0], 1'b0};
      end else begin
         tclk_now = bus_clock_ff;
      end
   end

   assign reject = (req_target_freq_hz < FREQ_MIN) || (req_target_freq_hz > FREQ_MAX) ||
                   (tclk_now == '0);
   assign rate_prod = PROD_W'(req_target_freq_hz) * PROD_W'(SPC);

   // One restoring division step
   assign trial    = {rem_ff, quo_ff[CLK_W-1]};
   assign diff     = trial - {1'b0, div_ff};
   assign ge       = (trial >= {1'b0, div_ff});
   assign quo_next = {quo_ff[CLK_W-2:0], ge};
   assign q_val    = quo_next[QUO_W-1:0];
   assign div_last = (cnt_ff == CNT_W'(DIV_STEPS - 1));
   assign mul_last = (cnt_ff == CNT_W'(MUL_STEPS - 1));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = reject ? S_DONE : S_SCALE;
            end
         end
         S_SCALE: state_in = S_DIV1;
         S_DIV1: begin
            if (div_last) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (mul_last) begin
               state_in = S_DIV2;
            end
         end
         S_DIV2: begin
            if (div_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and result register
   always_comb begin
      tclk_in      = tclk_ff;
      rate_in      = rate_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      mpl_in       = mpl_ff;
      mcd_in       = mcd_ff;
      psc_in       = psc_ff;
      cnt_in       = cnt_ff;
      res_ok_in    = res_ok_ff;
      res_psc_in   = res_psc_ff;
      res_rld_in   = res_rld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_psc_in   = rsp_psc_ff;
      rsp_rld_in   = rsp_rld_ff;
      case (state_ff)
         S_IDLE: begin
            // Latch the word; a reject goes straight to done with zeros
            tclk_in    = tclk_now;
            rate_in    = rate_prod[RATE_W-1:0];
            res_ok_in  = 1'b0;
            res_psc_in = '0;
            res_rld_in = '0;
         end
         S_SCALE: begin
            // Prescaler = clock / (65537 * rate)
            div_in = (DIV_W'(rate_ff) << 16) + DIV_W'(rate_ff);
            rem_in = '0;
            quo_in = tclk_ff;
            cnt_in = '0;
         end
         S_DIV1, S_DIV2: begin
            rem_in = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            quo_in = quo_next;
            cnt_in = cnt_ff + 1'b1;
            if (div_last && state_ff == S_DIV1) begin
               // Set up (prescale + 1) * rate
               psc_in = quo_next[PSC_W-1:0];
               mpl_in = MPL_W'(quo_next[PSC_W-1:0]) + 1'b1;
               mcd_in = DIV_W'(rate_ff);
               div_in = '0;
               cnt_in = '0;
            end
            if (div_last && state_ff == S_DIV2) begin
               // A zero quotient can only come at prescaler zero
               if (q_val != '0) begin
                  res_ok_in  = 1'b1;
                  res_psc_in = psc_ff;
                  res_rld_in = RLD_W'(q_val - 1'b1);
               end
            end
         end
         S_MUL: begin
            // Shift-add one multiplier bit per cycle
            if (mpl_ff[0]) begin
               div_in = div_ff + mcd_ff;
            end
            mcd_in = mcd_ff << 1;
            mpl_in = mpl_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
            if (mul_last) begin
               rem_in = '0;
               quo_in = tclk_ff;
               cnt_in = '0;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_psc_in   = res_psc_ff;
               rsp_rld_in   = res_rld_ff;
            end
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Clock configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         bus_clock_ff   <= BUS_CLOCK_RESET;
         bus_divided_ff <= BUS_DIVIDED_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BUS_CLOCK:   bus_clock_ff   <= csr_data;
            CSR_BUS_DIVIDED: bus_divided_ff <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      tclk_ff    <= tclk_in;
      rate_ff    <= rate_in;
      div_ff     <= div_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      mpl_ff     <= mpl_in;
      mcd_ff     <= mcd_in;
      psc_ff     <= psc_in;
      cnt_ff     <= cnt_in;
      res_ok_ff  <= res_ok_in;
      res_psc_ff <= res_psc_in;
      res_rld_ff <= res_rld_in;
      rsp_ok_ff  <= rsp_ok_in;
      rsp_psc_ff <= rsp_psc_in;
      rsp_rld_ff <= rsp_rld_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ok       = rsp_ok_ff;
   assign rsp_prescale = rsp_psc_ff;
   assign rsp_reload   = rsp_rld_ff;

   // A zero target skips the search and lands in done as a reject
   `TDS_ASSERT(a_zero_reject, clock, reset, (req_valid && req_ready && req_target_freq_hz == '0) |=> (state_ff == S_DONE && !res_ok_ff), "zero target not rejected")
   // A reject carries zero prescale and reload
   `TDS_ASSERT(a_reject_zero, clock, reset, (rsp_valid && !rsp_ok) |-> (rsp_prescale == '0 && rsp_reload == '0), "reject with nonzero fields")
   // Past prescaler zero the quotient is at least half its range
   `TDS_ASSERT(a_reload_big, clock, reset, (rsp_valid && rsp_ok && rsp_prescale != '0) |-> (rsp_reload >= 16'd32767), "reload too small for nonzero prescale")
   // The prescaler division hands over to the multiply
   `TDS_ASSERT(a_div1_to_mul, clock, reset, (state_ff == S_DIV1 && div_last) |=> (state_ff == S_MUL && cnt_ff == '0), "prescaler division did not hand over")

endmodule
